>>> hw/rtl/gtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gtd_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int ACC_W     = 48;
   localparam int COEF_W    = 16;
   localparam int COEF_FRAC = 14;
   localparam int BLEN_W    = 16;
   localparam int POW_W     = 48;
   localparam int CSR_W     = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR  = 2'd2;

   localparam logic [COEF_W-1:0] RST_COEF = 16'd28378;
   localparam logic [BLEN_W-1:0] RST_BLEN = 16'd16000;
   localparam logic [POW_W-1:0]  RST_THR  = 48'd1024000000;

   // shared multiplier: wide operand times one 16-bit digit of the other per cycle
   localparam int DIG_W     = 16;
   localparam int NDIG      = (ACC_W + DIG_W - 1) / DIG_W;
   localparam int B_W       = NDIG * DIG_W;
   localparam int DIG_IDX_W = $clog2(NDIG);
   localparam int OPA_W     = ACC_W + COEF_W;
   localparam int PP_W      = OPA_W + DIG_W + 1;
   localparam int PROD_W    = 2 * ACC_W + COEF_W;

   typedef enum logic [1:0] {
      MOP_COEF_Q1,
      MOP_Q1_SQ,
      MOP_Q2_SQ,
      MOP_CROSS
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMUL,
      ST_SUPD,
      ST_PSQ1,
      ST_WSQ1,
      ST_PSQ2,
      ST_WSQ2,
      ST_PCQ,
      ST_WCQ,
      ST_PX,
      ST_WX,
      ST_DIFF,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       mul_start;
      mul_op_type mul_op;
      logic       sample_load;
      logic       res_update;
      logic       sumsq_save;
      logic       diff_load;
      logic       res_clear;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic block_end;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> hw/rtl/gtd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module gtd_mul (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 clear,
   input  wire logic signed [gtd_pkg::OPA_W-1:0]     opa,
   input  wire logic signed [gtd_pkg::B_W-1:0]       opb,
   input  wire logic        [gtd_pkg::DIG_IDX_W-1:0] last,
   output logic                                      done,
   output logic signed [gtd_pkg::PROD_W-1:0]         acc
);
   import gtd_pkg::*;

   logic                        busy_ff, busy_in;
   logic [DIG_IDX_W-1:0]        dig_ff, dig_in;
   logic [DIG_IDX_W-1:0]        last_ff, last_in;
   logic signed [OPA_W-1:0]     a_ff, a_in;
   logic [B_W-1:0]              b_ff, b_in;
   logic signed [PROD_W-1:0]    acc_ff, acc_in;

   logic [DIG_W-1:0]            dig_raw;
   logic signed [DIG_W:0]       dig_s;
   logic signed [PP_W-1:0]      pp;
   logic signed [PROD_W-1:0]    pp_ext;

   always_comb begin
      dig_raw = b_ff[dig_ff*DIG_W +: DIG_W];
      // only the top digit carries the sign
      dig_s   = {(dig_ff == last_ff) ? dig_raw[DIG_W-1] : 1'b0, dig_raw};
      pp      = a_ff * dig_s;
      pp_ext  = PROD_W'(pp) <<< (DIG_W * dig_ff);
      done    = busy_ff && (dig_ff == last_ff);
   end

   always_comb begin
      busy_in = busy_ff;
      dig_in  = dig_ff;
      last_in = last_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         dig_in  = '0;
         last_in = last;
         a_in    = opa;
         b_in    = opb;
         if (clear) begin
            acc_in = '0;
         end
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_ext;
         dig_in = dig_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         dig_ff  <= '0;
         last_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         dig_ff  <= dig_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("multiplier started while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset) done |=> !busy_ff)
      else $error("multiplier still busy after last digit");
   a_dig_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (dig_ff <= last_ff))
      else $error("digit index ran past last digit");

endmodule
`default_nettype wire

>>> hw/rtl/gtd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gtd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire gtd_pkg::dp_status_type  status,
   output gtd_pkg::dp_cmd_type          cmd
);
   import gtd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.mul_op = MOP_COEF_Q1;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.sample_load = 1'b1;
               cmd.mul_start   = 1'b1;
               cmd.mul_op      = MOP_COEF_Q1;
               state_in        = ST_SMUL;
            end
         end
         ST_SMUL: begin
            if (status.mul_done) state_in = ST_SUPD;
         end
         ST_SUPD: begin
            cmd.res_update = 1'b1;
            state_in = status.block_end ? ST_PSQ1 : ST_IDLE;
         end
         ST_PSQ1: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MOP_Q1_SQ;
            state_in      = ST_WSQ1;
         end
         ST_WSQ1: begin
            if (status.mul_done) state_in = ST_PSQ2;
         end
         ST_PSQ2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MOP_Q2_SQ;
            state_in      = ST_WSQ2;
         end
         ST_WSQ2: begin
            if (status.mul_done) state_in = ST_PCQ;
         end
         ST_PCQ: begin
            // sum of squares leaves the accumulator as it restarts
            cmd.mul_start  = 1'b1;
            cmd.mul_op     = MOP_COEF_Q1;
            cmd.sumsq_save = 1'b1;
            state_in       = ST_WCQ;
         end
         ST_WCQ: begin
            if (status.mul_done) state_in = ST_PX;
         end
         ST_PX: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MOP_CROSS;
            state_in      = ST_WX;
         end
         ST_WX: begin
            if (status.mul_done) state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff_load = 1'b1;
            cmd.res_clear = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hw/rtl/gtd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module gtd_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire gtd_pkg::dp_cmd_type                  cmd,
   output gtd_pkg::dp_status_type                    status,
   input  wire logic [gtd_pkg::SAMPLE_W-1:0]         req_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_detected,
   output logic [gtd_pkg::POW_W-1:0]                 rsp_block_power,
   input  wire logic                                 csr_wr_en,
   input  wire logic [gtd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [gtd_pkg::CSR_W-1:0]            csr_wdata
);
   import gtd_pkg::*;

   localparam int UPD_W  = OPA_W + 2;
   localparam int DIFF_W = PROD_W + 1;
   localparam logic signed [UPD_W-1:0]  UPD_HALF  = UPD_W'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [DIFF_W-1:0] DIFF_HALF = DIFF_W'(1) <<< (COEF_FRAC - 1);

   // configuration
   logic signed [COEF_W-1:0] coef_ff, coef_in;
   logic [BLEN_W-1:0]        blen_ff, blen_in;
   logic [POW_W-1:0]         thr_ff, thr_in;

   // resonator
   logic signed [ACC_W-1:0]  q1_ff, q1_in, q2_ff, q2_in;
   logic [BLEN_W-1:0]        cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0]      sample_ff, sample_in;

   logic signed [PROD_W-1:0] sumsq_ff, sumsq_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_det_ff, rsp_det_in;
   logic [POW_W-1:0]         rsp_pow_ff, rsp_pow_in;

   // multiplier
   logic signed [OPA_W-1:0]  mul_opa;
   logic signed [B_W-1:0]    mul_opb;
   logic [DIG_IDX_W-1:0]     mul_last;
   logic                     mul_clear;
   logic                     mul_done;
   logic signed [PROD_W-1:0] mul_acc;

   logic signed [OPA_W-1:0]  prod_lo;
   logic signed [UPD_W-1:0]  upd_full, upd_rnd, upd_sum;
   logic                     sat_hi, sat_lo;
   logic signed [ACC_W-1:0]  q_new;
   logic [BLEN_W-1:0]        cnt_next, limit;
   logic signed [DIFF_W-1:0] x_full, x_rnd;
   logic                     pow_neg, pow_over;
   logic                     out_free;

   gtd_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .clear (mul_clear),
      .opa   (mul_opa),
      .opb   (mul_opb),
      .last  (mul_last),
      .done  (mul_done),
      .acc   (mul_acc)
   );

   always_comb begin
      mul_opa   = OPA_W'(q1_ff);
      mul_opb   = B_W'(coef_ff);
      mul_last  = '0;
      mul_clear = 1'b1;
      case (cmd.mul_op)
         MOP_COEF_Q1: begin
            mul_opa  = OPA_W'(q1_ff);
            mul_opb  = B_W'(coef_ff);
            mul_last = '0;
         end
         MOP_Q1_SQ: begin
            mul_opa  = OPA_W'(q1_ff);
            mul_opb  = B_W'(q1_ff);
            mul_last = DIG_IDX_W'(NDIG - 1);
         end
         MOP_Q2_SQ: begin
            mul_opa   = OPA_W'(q2_ff);
            mul_opb   = B_W'(q2_ff);
            mul_last  = DIG_IDX_W'(NDIG - 1);
            mul_clear = 1'b0;
         end
         MOP_CROSS: begin
            mul_opa  = mul_acc[OPA_W-1:0];
            mul_opb  = B_W'(q2_ff);
            mul_last = DIG_IDX_W'(NDIG - 1);
         end
         default: begin
            mul_opa = OPA_W'(q1_ff);
         end
      endcase
   end

   // resonator step: round(coef*q1) - q2 + sample, saturated
   always_comb begin
      prod_lo  = mul_acc[OPA_W-1:0];
      upd_full = UPD_W'(prod_lo) + UPD_HALF;
      upd_rnd  = upd_full >>> COEF_FRAC;
      upd_sum  = upd_rnd - UPD_W'(q2_ff) + signed'(UPD_W'(sample_ff));
      sat_hi   = !upd_sum[UPD_W-1] && (|upd_sum[UPD_W-2:ACC_W-1]);
      sat_lo   = upd_sum[UPD_W-1] && !(&upd_sum[UPD_W-2:ACC_W-1]);
      if (sat_hi) begin
         q_new = {1'b0, {(ACC_W-1){1'b1}}};
      end else if (sat_lo) begin
         q_new = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         q_new = upd_sum[ACC_W-1:0];
      end
      cnt_next = cnt_ff + 1'b1;
      limit    = (blen_ff == '0) ? BLEN_W'(1) : blen_ff;
   end

   // block power: q1^2 + q2^2 - round(coef*q1*q2)
   always_comb begin
      x_full   = DIFF_W'(mul_acc) + DIFF_HALF;
      x_rnd    = x_full >>> COEF_FRAC;
      diff_in  = cmd.diff_load ? (DIFF_W'(sumsq_ff) - x_rnd) : diff_ff;
      sumsq_in = cmd.sumsq_save ? mul_acc : sumsq_ff;
      pow_neg  = diff_ff[DIFF_W-1];
      pow_over = |diff_ff[DIFF_W-2:POW_W];
   end

   always_comb begin
      coef_in = coef_ff;
      blen_in = blen_ff;
      thr_in  = thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COEF: coef_in = csr_wdata[COEF_W-1:0];
            CSR_BLEN: blen_in = csr_wdata[BLEN_W-1:0];
            CSR_THR:  thr_in  = csr_wdata[POW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      q1_in     = q1_ff;
      q2_in     = q2_ff;
      cnt_in    = cnt_ff;
      sample_in = cmd.sample_load ? req_sample : sample_ff;
      if (cmd.res_clear) begin
         q1_in  = '0;
         q2_in  = '0;
         cnt_in = '0;
      end else if (cmd.res_update) begin
         q1_in  = q_new;
         q2_in  = q1_ff;
         cnt_in = cnt_next;
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff;
      rsp_det_in   = rsp_det_ff;
      rsp_pow_in   = rsp_pow_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (pow_neg) begin
            rsp_det_in = 1'b0;
            rsp_pow_in = '0;
         end else if (pow_over) begin
            rsp_det_in = 1'b1;
            rsp_pow_in = '1;
         end else begin
            rsp_pow_in = diff_ff[POW_W-1:0];
            rsp_det_in = diff_ff[POW_W-1:0] > thr_ff;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= RST_COEF;
         blen_ff      <= RST_BLEN;
         thr_ff       <= RST_THR;
         q1_ff        <= '0;
         q2_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         blen_ff      <= blen_in;
         thr_ff       <= thr_in;
         q1_ff        <= q1_in;
         q2_ff        <= q2_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      sumsq_ff   <= sumsq_in;
      diff_ff    <= diff_in;
      rsp_det_ff <= rsp_det_in;
      rsp_pow_ff <= rsp_pow_in;
   end

   assign status.mul_done  = mul_done;
   assign status.block_end = cnt_next >= limit;
   assign status.out_free  = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_detected    = rsp_det_ff;
   assign rsp_block_power = rsp_pow_ff;

endmodule
`default_nettype wire

>>> hw/rtl/goertzel_tone_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                                   direction
// req       req_valid/req_ready, req_sample         in
// rsp       rsp_valid/rsp_ready, rsp_detected,
//           rsp_block_power                         out
// csr       csr_wr_en, csr_index, csr_wdata         in, write only
//
// A sample is accepted, takes one pass of the shared 64x17 multiplier
// (coef*q1), then updates the resonator.
// At a block end coef*q1 is formed again, and q1^2, q2^2 and q2 times
// coef*q1 each take one multiplier cycle per 16-bit digit (3), plus issue steps.
// Synchronous reset clears the resonator, the sample count, the output slot and
// loads the register defaults. A waiting result does not block new samples;
// the next block end holds until that result is taken.
module goertzel_tone_detector (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [gtd_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_detected,
   output logic [gtd_pkg::POW_W-1:0]            rsp_block_power,
   input  wire logic                            csr_wr_en,
   input  wire logic [gtd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gtd_pkg::CSR_W-1:0]       csr_wdata
);
   import gtd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   gtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gtd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_detected    (rsp_detected),
      .rsp_block_power (rsp_block_power),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule
`default_nettype wire

>>> verif/tb_goertzel_tone_detector.sv
`timescale 1ns / 1ps
module tb_goertzel_tone_detector;
   import gtd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_SAMPLES = 90;

   localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (COEF_FRAC - 1);
   localparam logic signed [127:0] ACC_MAX    = (128'sd1 <<< (ACC_W - 1)) - 128'sd1;
   localparam logic signed [127:0] ACC_MIN    = -(128'sd1 <<< (ACC_W - 1));
   localparam logic signed [127:0] POWER_TOP  = (128'sd1 <<< POW_W) - 128'sd1;

   typedef struct packed {
      logic             detected;
      logic [POW_W-1:0] power;
   } tone_verdict_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_detected;
   logic [POW_W-1:0]     rsp_block_power;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // shadow of the detector
   logic signed [COEF_W-1:0] cfg_coef  = RST_COEF;
   logic [BLEN_W-1:0]        cfg_blen  = RST_BLEN;
   logic [POW_W-1:0]         cfg_thr   = RST_THR;
   logic signed [ACC_W-1:0]  res_q1    = '0;
   logic signed [ACC_W-1:0]  res_q2    = '0;
   logic [BLEN_W-1:0]        res_count = '0;

   logic [SAMPLE_W-1:0] sample_queue[$];
   tone_verdict_type    verdict_queue[$];

   bit quiet_phase = 1'b0;
   int send_gap    = 0;
   int take_stall  = 0;
   int mismatches  = 0;
   int samples_sent    = 0;
   int results_checked = 0;
   int detections      = 0;
   int configs_used    = 0;
   int cycle_count     = 0;

   goertzel_tone_detector u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_detected    (rsp_detected),
      .rsp_block_power (rsp_block_power),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // one resonator step; at block end forms the power and queues the verdict
   function automatic void goertzel_step(input logic [SAMPLE_W-1:0] smp);
      logic signed [127:0] c, a, b, t, u;
      logic [BLEN_W-1:0]   lim;
      tone_verdict_type    v;
      c = cfg_coef;
      a = res_q1;
      b = res_q2;
      t = c * a;
      t = (t + ROUND_HALF) >>> COEF_FRAC;
      t = t - b;
      u = {120'd0, smp};
      t = t + u;
      if (t > ACC_MAX)
         t = ACC_MAX;
      else if (t < ACC_MIN)
         t = ACC_MIN;
      res_q2 = res_q1;
      res_q1 = t[ACC_W-1:0];
      res_count = res_count + 1'b1;
      lim = (cfg_blen == '0) ? BLEN_W'(1) : cfg_blen;
      if (res_count < lim)
         return;
      a = res_q1;
      b = res_q2;
      t = a * a + b * b;
      u = c * a * b;
      u = (u + ROUND_HALF) >>> COEF_FRAC;
      t = t - u;
      if (t < 0) begin
         v.detected = 1'b0;
         v.power    = '0;
      end else if (t > POWER_TOP) begin
         v.detected = 1'b1;
         v.power    = '1;
      end else begin
         v.power    = t[POW_W-1:0];
         v.detected = v.power > cfg_thr;
      end
      verdict_queue.push_back(v);
      res_q1    = '0;
      res_q2    = '0;
      res_count = '0;
   endfunction

   // mostly back to back, some short gaps, the odd long one
   function automatic int idle_cycles();
      int r;
      if (quiet_phase)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_COEF: cfg_coef = val[COEF_W-1:0];
         CSR_BLEN: cfg_blen = val[BLEN_W-1:0];
         CSR_THR:  cfg_thr  = val[POW_W-1:0];
         default: ;
      endcase
   endtask

   // drain everything, then give the datapath time to finish a sample with no result
   task automatic settle();
      while (sample_queue.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      configs_used++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            goertzel_step(req_sample);
            samples_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0 || sample_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap != 0)
                  send_gap <= send_gap - 1;
            end else begin
               req_valid  <= 1'b1;
               req_sample <= sample_queue.pop_front();
               send_gap   <= idle_cycles();
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      tone_verdict_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         take_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result detected=%0b power=%0d", $realtime,
                           rsp_detected, rsp_block_power);
            end else begin
               want = verdict_queue.pop_front();
               results_checked++;
               if (rsp_detected)
                  detections++;
               if (rsp_detected !== want.detected || rsp_block_power !== want.power) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch detected exp %0b got %0b, power exp %0d got %0d",
                              $realtime, want.detected, rsp_detected, want.power,
                              rsp_block_power);
               end
            end
         end
         if (take_stall != 0) begin
            rsp_ready  <= 1'b0;
            take_stall <= take_stall - 1;
         end else begin
            rsp_ready  <= 1'b1;
            take_stall <= idle_cycles();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  verdict_queue.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int                ph, i, pattern;
      logic [SAMPLE_W-1:0] level, s;
      logic [47:0]       junk;
      logic [POW_W-1:0]  thr_pick;
      logic [63:0]       wide_rand;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // defaults: long block, then shorten it to the count already taken
      @(negedge clock);
      sample_queue.push_back(8'd200);
      sample_queue.push_back(8'd17);
      sample_queue.push_back(8'd99);
      settle();
      write_reg(CSR_BLEN, 48'd3);
      write_reg(CSR_UNUSED, 48'hFFFF_FFFF_FFFF);
      @(negedge clock);
      sample_queue.push_back(8'd128);
      settle();

      // zero length acts as one; one-sample power is sample squared
      write_reg(CSR_BLEN, 48'hABCD_0000_0000);
      write_reg(CSR_THR, 48'd255);
      @(negedge clock);
      sample_queue.push_back(8'd16);
      sample_queue.push_back(8'd255);
      sample_queue.push_back(8'd0);
      settle();
      write_reg(CSR_THR, 48'd0);
      @(negedge clock);
      sample_queue.push_back(8'd0);
      sample_queue.push_back(8'd1);
      settle();
      write_reg(CSR_THR, 48'd256);
      @(negedge clock);
      sample_queue.push_back(8'd16);
      settle();
      write_reg(CSR_BLEN, 48'd1);
      write_reg(CSR_THR, 48'hFFFF_FFFF_FFFF);
      @(negedge clock);
      sample_queue.push_back(8'd255);
      settle();

      // coefficient extremes and zero, tone at the matching bin
      write_reg(CSR_COEF, 48'h0000_0000_8000);
      write_reg(CSR_BLEN, 48'd4);
      write_reg(CSR_THR, 48'd0);
      @(negedge clock);
      for (i = 0; i < 4; i++)
         sample_queue.push_back((i % 2) ? 8'd0 : 8'd255);
      settle();
      write_reg(CSR_COEF, 48'hFFFF_FFFF_7FFF);
      @(negedge clock);
      for (i = 0; i < 4; i++)
         sample_queue.push_back(8'd255);
      settle();
      write_reg(CSR_COEF, 48'd0);
      @(negedge clock);
      for (i = 0; i < 4; i++)
         sample_queue.push_back((i % 4 < 2) ? 8'd255 : 8'd0);
      settle();

      // longest block: start it, then cut it short
      write_reg(CSR_BLEN, 48'hFFFF);
      @(negedge clock);
      sample_queue.push_back(8'd255);
      sample_queue.push_back(8'd1);
      settle();
      write_reg(CSR_BLEN, 48'd2);
      @(negedge clock);
      sample_queue.push_back(8'd254);
      settle();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         junk = rand48();
         case ($urandom_range(0, 5))
            0: write_reg(CSR_COEF, {junk[47:16], 16'h8000});
            1: write_reg(CSR_COEF, {junk[47:16], 16'h7FFF});
            2: write_reg(CSR_COEF, {junk[47:16], 16'h0000});
            default: write_reg(CSR_COEF, junk);
         endcase
         junk = rand48();
         case ($urandom_range(0, 9))
            0: write_reg(CSR_BLEN, {junk[47:16], 16'd0});
            1: write_reg(CSR_BLEN, {junk[47:16], 16'd1});
            2: write_reg(CSR_BLEN, {junk[47:16], 16'($urandom_range(60, 200))});
            default: write_reg(CSR_BLEN, {junk[47:16], 16'($urandom_range(2, 24))});
         endcase
         wide_rand = {$urandom, $urandom};
         case ($urandom_range(0, 5))
            0: thr_pick = '0;
            1: thr_pick = '1;
            default: thr_pick = POW_W'(wide_rand >> $urandom_range(16, 60));
         endcase
         write_reg(CSR_THR, thr_pick);
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_UNUSED, rand48());

         quiet_phase = ($urandom_range(0, 3) == 0);
         pattern = $urandom_range(0, 3);
         level = 8'($urandom_range(0, 255));
         @(negedge clock);
         for (i = 0; i < PHASE_SAMPLES; i++) begin
            case (pattern)
               0: s = 8'($urandom_range(0, 255));
               1: s = (i % 2) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(240, 255));
               2: s = (i % 4 < 2) ? 8'($urandom_range(224, 255)) : 8'($urandom_range(0, 31));
               default: s = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : level;
            endcase
            sample_queue.push_back(s);
         end
         settle();
      end

      $display("Ran %0d samples across %0d register settings (coefficient, length and",
               samples_sent, configs_used);
      $display("threshold extremes included); %0d block results checked, %0d flagged a tone.",
               results_checked, detections);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
